@@ rtl/core/pgc_pkg.sv @@
// Package for the proximity gesture classifier.
// Holds the request and result structs, configuration struct, codes and decision function.
// No dependencies.
package pgc_pkg;

  // Field widths
  localparam int unsigned DistW  = 9;
  localparam int unsigned CountW = 8;
  localparam int unsigned MsW    = 12;
  localparam int unsigned GestW  = 2;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 12;

  // Gesture codes
  localparam logic [GestW-1:0] GestNone  = 2'd0;
  localparam logic [GestW-1:0] GestSkip  = 2'd1;
  localparam logic [GestW-1:0] GestPause = 2'd2;
  localparam logic [GestW-1:0] GestPrev  = 2'd3;

  // Request kinds
  localparam logic KindTick   = 1'b0;
  localparam logic KindSample = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegSkipHold    = 4'd0;
  localparam logic [CfgIdxW-1:0] RegPauseHold   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegPauseMinDst = 4'd2;
  localparam logic [CfgIdxW-1:0] RegPrevHold    = 4'd3;
  localparam logic [CfgIdxW-1:0] RegPrevMaxDst  = 4'd4;
  localparam logic [CfgIdxW-1:0] RegMaxDst      = 4'd5;
  localparam logic [CfgIdxW-1:0] RegWindowMs    = 4'd6;
  localparam logic [CfgIdxW-1:0] RegHoldoffMs   = 4'd7;

  // Register reset values
  localparam logic [CountW-1:0] SkipHoldRst    = 8'd9;
  localparam logic [CountW-1:0] PauseHoldRst   = 8'd18;
  localparam logic [DistW-1:0]  PauseMinDstRst = 9'd6;
  localparam logic [CountW-1:0] PrevHoldRst    = 8'd20;
  localparam logic [DistW-1:0]  PrevMaxDstRst  = 9'd4;
  localparam logic [DistW-1:0]  MaxDstRst      = 9'd30;
  localparam logic [MsW-1:0]    WindowMsRst    = 12'd1000;
  localparam logic [MsW-1:0]    HoldoffMsRst   = 12'd1500;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic             kind;
    logic [DistW-1:0] distance_cm;
  } pgc_in_t;

  typedef struct packed {
    logic [GestW-1:0]  gesture;
    logic [CountW-1:0] detection_count;
    logic [DistW-1:0]  closest_cm;
  } pgc_out_t;

  typedef struct packed {
    logic [CountW-1:0] skip_hold;
    logic [CountW-1:0] pause_hold;
    logic [DistW-1:0]  pause_min_distance;
    logic [CountW-1:0] prev_hold;
    logic [DistW-1:0]  prev_max_distance;
    logic [DistW-1:0]  nearest_start;
    logic [MsW-1:0]    window_ms;
    logic [MsW-1:0]    holdoff_ms;
  } pgc_cfg_t;

  // Gesture decision; pause overrides skip and previous
  function automatic logic [GestW-1:0] decide(logic [CountW-1:0] cnt,
                                              logic [DistW-1:0] mn,
                                              pgc_cfg_t cfg);
    logic [GestW-1:0] g;
    g = GestNone;
    if (cnt <= cfg.skip_hold) begin
      g = GestSkip;
    end else if (mn <= cfg.prev_max_distance && cnt >= cfg.prev_hold) begin
      g = GestPrev;
    end
    if (cnt >= cfg.pause_hold && mn >= cfg.pause_min_distance) begin
      g = GestPause;
    end
    return g;
  endfunction

endpackage

@@ rtl/core/proximity_gesture_classifier.sv @@
// Top level of the proximity gesture classifier.
// Depends on pgc_pkg, pgc_cfg_regs and pgc_core.
//
// Accepts one request (a millisecond tick or a distance sample) every clock
// cycle while not stalled. A request is captured in an input register and
// updates the window state when it leaves that register; on the tick that
// closes a window, the result register is loaded at the same clock edge, so
// out_valid_o rises once the closing tick has passed the input register.
// The only stall is a closing tick meeting a result register that is still
// waiting to be taken. Configuration writes are accepted in every cycle and
// take effect at once; write only while the block is idle.
module proximity_gesture_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pgc_pkg::pgc_in_t              in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pgc_pkg::pgc_out_t             out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pgc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pgc_pkg::CfgDataW-1:0]  cfg_data_i
);

  pgc_pkg::pgc_cfg_t cfg;
  pgc_pkg::pgc_in_t  in_q;
  pgc_pkg::pgc_out_t out_q, res;
  logic              in_valid_q, out_valid_q;
  logic              res_valid, stall, step;

  assign cfg_ready_o = 1'b1;

  pgc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Hold the staged request only if it has a result with nowhere to go
  assign stall      = in_valid_q && res_valid && out_valid_q && !out_ready_i;
  assign step       = in_valid_q && !stall;
  assign in_ready_o = !stall;

  pgc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_i;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A stalled request stays staged
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> in_valid_q && $stable(in_q))
    else $error("staged request lost during stall");

  // A new result only comes from a processed closing tick
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(step && res_valid))
    else $error("result appeared without a closing tick");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(step && res_valid))
    else $error("pending result overwritten");

endmodule

@@ rtl/core/pgc_cfg_regs.sv @@
// Configuration register file of the proximity gesture classifier.
// Depends on pgc_pkg.
module pgc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pgc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pgc_pkg::CfgDataW-1:0]   cfg_data_i,
  output pgc_pkg::pgc_cfg_t              cfg_o
);

  pgc_pkg::pgc_cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.skip_hold          <= pgc_pkg::SkipHoldRst;
      cfg_q.pause_hold         <= pgc_pkg::PauseHoldRst;
      cfg_q.pause_min_distance <= pgc_pkg::PauseMinDstRst;
      cfg_q.prev_hold          <= pgc_pkg::PrevHoldRst;
      cfg_q.prev_max_distance  <= pgc_pkg::PrevMaxDstRst;
      cfg_q.nearest_start      <= pgc_pkg::MaxDstRst;
      cfg_q.window_ms          <= pgc_pkg::WindowMsRst;
      cfg_q.holdoff_ms         <= pgc_pkg::HoldoffMsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pgc_pkg::RegSkipHold:    cfg_q.skip_hold <= cfg_data_i[pgc_pkg::CountW-1:0];
        pgc_pkg::RegPauseHold:   cfg_q.pause_hold <= cfg_data_i[pgc_pkg::CountW-1:0];
        pgc_pkg::RegPauseMinDst: cfg_q.pause_min_distance <= cfg_data_i[pgc_pkg::DistW-1:0];
        pgc_pkg::RegPrevHold:    cfg_q.prev_hold <= cfg_data_i[pgc_pkg::CountW-1:0];
        pgc_pkg::RegPrevMaxDst:  cfg_q.prev_max_distance <= cfg_data_i[pgc_pkg::DistW-1:0];
        pgc_pkg::RegMaxDst:      cfg_q.nearest_start <= cfg_data_i[pgc_pkg::DistW-1:0];
        pgc_pkg::RegWindowMs:    cfg_q.window_ms <= cfg_data_i[pgc_pkg::MsW-1:0];
        pgc_pkg::RegHoldoffMs:   cfg_q.holdoff_ms <= cfg_data_i[pgc_pkg::MsW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/pgc_core.sv @@
// Window/holdoff sequencer and gesture decision of the proximity gesture classifier.
// Depends on pgc_pkg.
module pgc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  pgc_pkg::pgc_in_t   item_i,
  input  pgc_pkg::pgc_cfg_t  cfg_i,
  output logic               res_valid_o,
  output pgc_pkg::pgc_out_t  res_o
);

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhWindow  = 2'd1,
    PhHoldoff = 2'd2
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [pgc_pkg::MsW-1:0]         elapsed_q, elapsed_d;
  logic [pgc_pkg::CountW-1:0]      hit_q, hit_d;
  logic [pgc_pkg::DistW-1:0]       nearest_q, nearest_d;
  logic [pgc_pkg::MsW:0]           elapsed_inc;
  logic                            is_hit;

  assign elapsed_inc = {1'b0, elapsed_q} + {{pgc_pkg::MsW{1'b0}}, 1'b1};
  assign is_hit      = (item_i.kind == pgc_pkg::KindSample) && (item_i.distance_cm != '0);

  // Next state and result for the item at hand
  always_comb begin
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    hit_d       = hit_q;
    nearest_d   = nearest_q;
    res_valid_o = 1'b0;
    unique case (phase_q)
      PhWindow: begin
        if (item_i.kind == pgc_pkg::KindSample) begin
          if (is_hit) begin
            if (hit_q != pgc_pkg::CountMax) hit_d = hit_q + 1'b1;
            if (item_i.distance_cm < nearest_q) nearest_d = item_i.distance_cm;
          end
        end else if (elapsed_inc >= {1'b0, cfg_i.window_ms}) begin
          res_valid_o = 1'b1;
          elapsed_d   = '0;
          phase_d     = (cfg_i.holdoff_ms == '0) ? PhIdle : PhHoldoff;
        end else begin
          elapsed_d = elapsed_inc[pgc_pkg::MsW-1:0];
        end
      end
      PhHoldoff: begin
        if (item_i.kind == pgc_pkg::KindTick) begin
          if (elapsed_inc >= {1'b0, cfg_i.holdoff_ms}) begin
            elapsed_d = '0;
            phase_d   = PhIdle;
          end else begin
            elapsed_d = elapsed_inc[pgc_pkg::MsW-1:0];
          end
        end
      end
      default: begin
        // idle: a nonzero sample opens the window, itself not counted
        if (is_hit) begin
          phase_d   = PhWindow;
          elapsed_d = '0;
          hit_d     = '0;
          nearest_d = cfg_i.nearest_start;
        end else begin
          phase_d = PhIdle;
        end
      end
    endcase
  end

  assign res_o.gesture         = pgc_pkg::decide(hit_q, nearest_q, cfg_i);
  assign res_o.detection_count = hit_q;
  assign res_o.closest_cm      = nearest_q;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      elapsed_q <= '0;
      hit_q     <= '0;
      nearest_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      hit_q     <= hit_d;
      nearest_q <= nearest_d;
    end
  end

endmodule

@@ tb/sv/tb_proximity_gesture_classifier.sv @@
// Self-checking testbench for proximity_gesture_classifier.
// Predicts every decision in a behavioural tracker of the window state and checks each result.
// Depends on pgc_pkg and the proximity_gesture_classifier RTL.
module tb_proximity_gesture_classifier;

  localparam int Period        = 20;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 4;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhWindow  = 2'd1,
    PhHoldoff = 2'd2
  } win_phase_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  pgc_pkg::pgc_in_t             in_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  pgc_pkg::pgc_out_t            out_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [pgc_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [pgc_pkg::CfgDataW-1:0] cfg_data_i;

  // Tracker copy of the registers and window state
  pgc_pkg::pgc_cfg_t          regs;
  win_phase_e                 win_phase;
  int unsigned                win_ticks;
  logic [pgc_pkg::CountW-1:0] win_hits;
  logic [pgc_pkg::DistW-1:0]  win_nearest;

  pgc_pkg::pgc_out_t gesture_q[$];
  int unsigned       closed_windows;
  int unsigned       mismatches;
  int unsigned       quiet_cycles;
  int unsigned       sink_hold;
  bit                bursts_on;

  proximity_gesture_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(Period / 2) clk_i = ~clk_i;

  // Gesture decision: pause overrides skip and previous
  function automatic logic [pgc_pkg::GestW-1:0] classify(logic [pgc_pkg::CountW-1:0] hits,
                                                         logic [pgc_pkg::DistW-1:0] nearest);
    logic [pgc_pkg::GestW-1:0] g;
    g = pgc_pkg::GestNone;
    if (hits <= regs.skip_hold) begin
      g = pgc_pkg::GestSkip;
    end else if (nearest <= regs.prev_max_distance && hits >= regs.prev_hold) begin
      g = pgc_pkg::GestPrev;
    end
    if (hits >= regs.pause_hold && nearest >= regs.pause_min_distance) begin
      g = pgc_pkg::GestPause;
    end
    return g;
  endfunction

  // Advance the window tracker by one accepted request
  function automatic void track_gesture(pgc_pkg::pgc_in_t req);
    pgc_pkg::pgc_out_t res;
    case (win_phase)
      PhWindow: begin
        if (req.kind == pgc_pkg::KindSample) begin
          if (req.distance_cm != '0) begin
            if (win_hits != pgc_pkg::CountMax) win_hits++;
            if (req.distance_cm < win_nearest) win_nearest = req.distance_cm;
          end
        end else if (win_ticks + 1 >= regs.window_ms) begin
          res.gesture         = classify(win_hits, win_nearest);
          res.detection_count = win_hits;
          res.closest_cm      = win_nearest;
          gesture_q.push_back(res);
          closed_windows++;
          win_ticks = 0;
          win_phase = (regs.holdoff_ms == '0) ? PhIdle : PhHoldoff;
        end else begin
          win_ticks++;
        end
      end
      PhHoldoff: begin
        // samples are ignored while holding off
        if (req.kind == pgc_pkg::KindTick) begin
          if (win_ticks + 1 >= regs.holdoff_ms) begin
            win_ticks = 0;
            win_phase = PhIdle;
          end else begin
            win_ticks++;
          end
        end
      end
      default: begin
        if (req.kind == pgc_pkg::KindSample && req.distance_cm != '0) begin
          win_phase   = PhWindow;
          win_ticks   = 0;
          win_hits    = '0;
          win_nearest = regs.nearest_start;
        end else begin
          win_phase = PhIdle;
        end
      end
    endcase
  endfunction

  // Send one request and wait for it to be taken
  task automatic send_request(pgc_pkg::pgc_in_t req);
    if (bursts_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_gesture(req);
  endtask

  task automatic send_ticks(int unsigned n);
    pgc_pkg::pgc_in_t req;
    req.kind        = pgc_pkg::KindTick;
    req.distance_cm = '0;
    repeat (n) send_request(req);
  endtask

  task automatic send_sample(logic [pgc_pkg::DistW-1:0] range_cm);
    pgc_pkg::pgc_in_t req;
    req.kind        = pgc_pkg::KindSample;
    req.distance_cm = range_cm;
    send_request(req);
  endtask

  // Stop sending and let every pending result drain out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write; the caller lowers cfg_valid_i after its last write
  task automatic write_reg(logic [pgc_pkg::CfgIdxW-1:0] idx,
                           logic [pgc_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      pgc_pkg::RegSkipHold:    regs.skip_hold          = data[pgc_pkg::CountW-1:0];
      pgc_pkg::RegPauseHold:   regs.pause_hold         = data[pgc_pkg::CountW-1:0];
      pgc_pkg::RegPauseMinDst: regs.pause_min_distance = data[pgc_pkg::DistW-1:0];
      pgc_pkg::RegPrevHold:    regs.prev_hold          = data[pgc_pkg::CountW-1:0];
      pgc_pkg::RegPrevMaxDst:  regs.prev_max_distance  = data[pgc_pkg::DistW-1:0];
      pgc_pkg::RegMaxDst:      regs.nearest_start      = data[pgc_pkg::DistW-1:0];
      pgc_pkg::RegWindowMs:    regs.window_ms          = data[pgc_pkg::MsW-1:0];
      pgc_pkg::RegHoldoffMs:   regs.holdoff_ms         = data[pgc_pkg::MsW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(pgc_pkg::pgc_cfg_t s);
    settle();
    write_reg(pgc_pkg::RegSkipHold,    pgc_pkg::CfgDataW'(s.skip_hold));
    write_reg(pgc_pkg::RegPauseHold,   pgc_pkg::CfgDataW'(s.pause_hold));
    write_reg(pgc_pkg::RegPauseMinDst, pgc_pkg::CfgDataW'(s.pause_min_distance));
    write_reg(pgc_pkg::RegPrevHold,    pgc_pkg::CfgDataW'(s.prev_hold));
    write_reg(pgc_pkg::RegPrevMaxDst,  pgc_pkg::CfgDataW'(s.prev_max_distance));
    write_reg(pgc_pkg::RegMaxDst,      pgc_pkg::CfgDataW'(s.nearest_start));
    write_reg(pgc_pkg::RegWindowMs,    pgc_pkg::CfgDataW'(s.window_ms));
    write_reg(pgc_pkg::RegHoldoffMs,   pgc_pkg::CfgDataW'(s.holdoff_ms));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly typical values, now and then one of the two ends
  function automatic int unsigned choose_setting(int unsigned lo, int unsigned hi,
                                                 int unsigned typ);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, typ);
    endcase
  endfunction

  function automatic logic [pgc_pkg::DistW-1:0] rand_distance();
    case ($urandom_range(0, 9))
      0:             return '0;
      1, 2, 3, 4:    return pgc_pkg::DistW'($urandom_range(1, 40));
      default:       return pgc_pkg::DistW'($urandom_range(1, 500));
    endcase
  endfunction

  // Defaults after reset: thresholds at reset values, window and holdoff cut short once running
  task automatic test_reset_values();
    pgc_pkg::pgc_in_t req;
    req.kind        = pgc_pkg::KindTick;
    req.distance_cm = '0;
    send_request(req);        // tick while idle
    send_sample('0);          // no echo while idle
    send_sample(9'd150);      // opens the window, not counted
    send_sample(9'd511);      // beyond range, still a hit
    send_sample('0);
    repeat (20) send_sample(9'd4);
    send_ticks(5);
    settle();
    write_reg(pgc_pkg::RegWindowMs, 12'd6);
    cfg_valid_i <= 1'b0;
    send_ticks(1);
    send_sample(9'd77);       // ignored in holdoff
    send_ticks(3);
    settle();
    write_reg(pgc_pkg::RegHoldoffMs, 12'd4);
    cfg_valid_i <= 1'b0;
    send_ticks(1);
  endtask

  // One window per gesture code, zero holdoff so each reopens at once
  task automatic test_decisions();
    pgc_pkg::pgc_cfg_t s;
    s = '{skip_hold: 8'd2, pause_hold: 8'd6, pause_min_distance: 9'd20, prev_hold: 8'd4,
          prev_max_distance: 9'd10, nearest_start: 9'd500, window_ms: 12'd2,
          holdoff_ms: 12'd0};
    load_regs(s);
    // skip
    send_sample(9'd100);
    send_sample(9'd50);
    send_ticks(2);
    // previous
    send_sample(9'd100);
    repeat (4) send_sample(9'd8);
    send_ticks(2);
    // none
    send_sample(9'd100);
    repeat (4) send_sample(9'd15);
    send_ticks(2);
    // pause
    send_sample(9'd100);
    repeat (6) send_sample(9'd30);
    send_ticks(2);
  endtask

  task automatic test_window_edges();
    pgc_pkg::pgc_cfg_t s;
    // low ends everywhere: zero window closes on its first tick
    s = '{skip_hold: 8'd0, pause_hold: 8'd0, pause_min_distance: 9'd0, prev_hold: 8'd0,
          prev_max_distance: 9'd0, nearest_start: 9'd1, window_ms: 12'd0,
          holdoff_ms: 12'd0};
    load_regs(s);
    send_sample(9'd1);
    send_ticks(1);
    send_sample(9'd2);
    send_sample(9'd1);
    send_ticks(1);
    // window cut short mid-way; start distance only latched at open
    s = '{skip_hold: 8'd1, pause_hold: 8'd3, pause_min_distance: 9'd41, prev_hold: 8'd2,
          prev_max_distance: 9'd40, nearest_start: 9'd40, window_ms: 12'd10,
          holdoff_ms: 12'd3};
    load_regs(s);
    send_sample(9'd9);
    send_ticks(4);
    send_sample(9'd45);
    send_sample(9'd45);
    settle();
    write_reg(pgc_pkg::RegMaxDst, 12'd7);
    write_reg(pgc_pkg::RegWindowMs, 12'd2);
    write_reg(4'd8, pgc_pkg::CfgDataW'($urandom));      // unmapped, must be ignored
    write_reg(4'd15, pgc_pkg::CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
    send_ticks(1);
    send_sample(9'd3);
    send_ticks(1);
    send_sample(9'd3);
    send_ticks(2);
  endtask

  task automatic test_count_saturation();
    pgc_pkg::pgc_cfg_t s;
    s = '{skip_hold: 8'd254, pause_hold: 8'd255, pause_min_distance: 9'd1, prev_hold: 8'd255,
          prev_max_distance: 9'd500, nearest_start: 9'd500, window_ms: 12'd1,
          holdoff_ms: 12'd1};
    load_regs(s);
    send_sample(9'd300);
    repeat (260) send_sample(pgc_pkg::DistW'($urandom_range(1, 500)));
    send_ticks(2);
  endtask

  // High ends: longest window and holdoff, each cut short once running
  task automatic test_long_window();
    pgc_pkg::pgc_cfg_t s;
    s = '{skip_hold: 8'd0, pause_hold: 8'd255, pause_min_distance: 9'd500, prev_hold: 8'd0,
          prev_max_distance: 9'd500, nearest_start: 9'd500, window_ms: 12'd4095,
          holdoff_ms: 12'd4095};
    load_regs(s);
    send_sample(9'd256);
    send_sample(9'd500);
    send_sample(9'd255);
    send_ticks(4);
    settle();
    write_reg(pgc_pkg::RegWindowMs, 12'd5);
    cfg_valid_i <= 1'b0;
    send_ticks(1);
    send_ticks(3);
    send_sample(9'd12);       // ignored in holdoff
    settle();
    write_reg(pgc_pkg::RegHoldoffMs, 12'd4);
    cfg_valid_i <= 1'b0;
    send_ticks(1);
    send_sample(9'd12);
    send_ticks(1);
  endtask

  // Random settings, then well-formed windows with random content plus noise
  task automatic test_random_traffic();
    pgc_pkg::pgc_cfg_t s;
    pgc_pkg::pgc_in_t  req;
    int unsigned       useful;
    int unsigned       first_closed;
    bit                counted;
    useful       = 0;
    first_closed = closed_windows;
    while (useful < 380 || closed_windows - first_closed < 16) begin
      if (useful >= 300) bursts_on = 1'b0;
      s.skip_hold          = pgc_pkg::CountW'(choose_setting(0, 255, 20));
      s.pause_hold         = pgc_pkg::CountW'(choose_setting(0, 255, 40));
      s.pause_min_distance = pgc_pkg::DistW'(choose_setting(0, 500, 60));
      s.prev_hold          = pgc_pkg::CountW'(choose_setting(0, 255, 30));
      s.prev_max_distance  = pgc_pkg::DistW'(choose_setting(0, 500, 60));
      s.nearest_start      = pgc_pkg::DistW'(choose_setting(1, 500, 500));
      s.window_ms          = pgc_pkg::MsW'(choose_setting(0, 60, 16));
      s.holdoff_ms         = pgc_pkg::MsW'(choose_setting(0, 30, 10));
      load_regs(s);
      repeat ($urandom_range(30, 90)) begin
        req.kind        = pgc_pkg::KindSample;
        req.distance_cm = rand_distance();
        case (win_phase)
          PhWindow: begin
            if ($urandom_range(0, 9) < 5) req.kind = pgc_pkg::KindTick;
            counted = 1'b1;
          end
          PhHoldoff: begin
            if ($urandom_range(0, 4) != 0) req.kind = pgc_pkg::KindTick;
            counted = (req.kind == pgc_pkg::KindTick);
          end
          default: begin
            if ($urandom_range(0, 5) == 0) begin
              // noise while idle
              req.kind = $urandom_range(0, 1) ? pgc_pkg::KindSample : pgc_pkg::KindTick;
              req.distance_cm = '0;
            end else if (req.distance_cm == '0) begin
              req.distance_cm = pgc_pkg::DistW'($urandom_range(1, 500));
            end
            counted = (req.kind == pgc_pkg::KindSample && req.distance_cm != '0);
          end
        endcase
        if (req.kind == pgc_pkg::KindTick) req.distance_cm = pgc_pkg::DistW'($urandom);
        send_request(req);
        if (counted) useful++;
      end
    end
  endtask

  // Result sink with bursts of back-pressure
  always @(posedge clk_i) begin
    if (sink_hold == 0 && bursts_on && $urandom_range(0, 11) == 0) begin
      sink_hold = $urandom_range(1, 11);
    end
    if (sink_hold != 0) begin
      sink_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each taken result with the oldest predicted decision
  always @(posedge clk_i) begin : check_results
    pgc_pkg::pgc_out_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gesture_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with none pending, expected nothing, got %p", $time, out_o);
      end else begin
        exp_res = gesture_q.pop_front();
        if (out_o.gesture !== exp_res.gesture) begin
          mismatches++;
          $display("%0t: gesture expected %0d, got %0d",
                   $time, exp_res.gesture, out_o.gesture);
        end
        if (out_o.detection_count !== exp_res.detection_count) begin
          mismatches++;
          $display("%0t: detection_count expected %0d, got %0d",
                   $time, exp_res.detection_count, out_o.detection_count);
        end
        if (out_o.closest_cm !== exp_res.closest_cm) begin
          mismatches++;
          $display("%0t: closest_cm expected %0d, got %0d",
                   $time, exp_res.closest_cm, out_o.closest_cm);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_i        <= '0;
    out_ready_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    regs = '{skip_hold: pgc_pkg::SkipHoldRst, pause_hold: pgc_pkg::PauseHoldRst,
             pause_min_distance: pgc_pkg::PauseMinDstRst, prev_hold: pgc_pkg::PrevHoldRst,
             prev_max_distance: pgc_pkg::PrevMaxDstRst, nearest_start: pgc_pkg::MaxDstRst,
             window_ms: pgc_pkg::WindowMsRst, holdoff_ms: pgc_pkg::HoldoffMsRst};
    win_phase      = PhIdle;
    win_ticks      = 0;
    win_hits       = '0;
    win_nearest    = '0;
    closed_windows = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    sink_hold      = 0;
    bursts_on      = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_decisions();
    test_window_edges();
    test_count_saturation();
    test_long_window();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
